>>> sv/jsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg - shared types and helpers for the JSON string unescaper
// Job word layout, error codes, character codes, hex/escape/UTF-8 helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // job queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // error codes reported on the result channel
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BSL_END   = 3'd1,
    ERR_TRUNC_U   = 3'd2,
    ERR_BAD_HEX   = 3'd3,
    ERR_BAD_ESC   = 3'd4,
    ERR_BAD_LOW   = 3'd5
  } err_t;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] HI_SURR_LO = 16'hd800;
  localparam logic [15:0] HI_SURR_HI = 16'hdbff;
  localparam logic [15:0] LO_SURR_LO = 16'hdc00;
  localparam logic [15:0] LO_SURR_HI = 16'hdfff;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // one accepted input's worth of result bytes
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;  // index of final byte
    logic            done;      // final byte ends the string
    err_t            err;
  } job_t;

  // queue head as seen by the serializer
  typedef struct packed {
    logic valid;
    job_t job;
  } qhead_t;

  typedef enum logic [1:0] {
    ESC_BYTE,
    ESC_UNI,
    ESC_BAD
  } esc_kind_t;

  typedef struct packed {
    esc_kind_t  kind;
    logic [7:0] val;
  } esc_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } hex_t;

  function automatic esc_t simple_escape(input logic [7:0] c);
    esc_t e;
    e.kind = ESC_BYTE;
    e.val  = c;
    unique case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: e.val = c;
      CH_B: e.val = 8'h08;
      CH_F: e.val = 8'h0c;
      CH_N: e.val = 8'h0a;
      CH_R: e.val = 8'h0d;
      CH_T: e.val = 8'h09;
      CH_U: e.kind = ESC_UNI;
      default: e.kind = ESC_BAD;
    endcase
    return e;
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.bad = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

  function automatic job_t utf8_encode(input logic [20:0] cp);
    job_t j;
    j = '0;
    j.err = ERR_NONE;
    if (cp <= 21'h7f) begin
      j.bytes[0] = cp[7:0];
      j.last_idx = 2'd0;
    end else if (cp <= 21'h7ff) begin
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
      j.last_idx = 2'd1;
    end else if (cp <= 21'hffff) begin
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
      j.last_idx = 2'd2;
    end else begin
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
      j.last_idx = 2'd3;
    end
    return j;
  endfunction

endpackage
`default_nettype wire

>>> sv/json_string_unescape_utf8.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8 - JSON string body unescaper, UTF-8 output
// Raw body bytes in, decoded UTF-8 bytes out, with per-string error codes.
// ----------------------------------------------------------------------------
// Bytes of one escaped string body are pushed one word per cycle, the last
// one flagged by in_end_of_string. The decoder takes a byte every cycle the
// job queue has room and turns it into a job of 0 to 4 result bytes; the
// serializer drains the queue one result word per cycle while pop is held.
// A plain byte gives one word, so plain text then flows at 1 byte/cycle and
// is registered only in the job queue. A \uXXXX escape gives 1-4 words,
// which occupy the serializer in turn; the four-deep job queue absorbs these
// bursts, and the input stalls (full) only once four jobs are waiting.
// Sustained rate is thus one word per cycle, set by the one-byte serializer.
// Errors produce one word with out_byte 0, string_done set and the code on
// out_error_code; later input up to the end mark produces nothing.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input queue side
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_string,
  // result queue side
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run,
  output logic            out_string_done,
  output logic [2:0]      out_error_code
);

  jsu_pkg::job_t   job;
  logic            job_valid;
  logic            accept;
  jsu_pkg::qhead_t head;
  logic            head_pop;

  // a word is taken whenever the queue has room, even if it yields no result
  assign accept = push && !full;

  // decoder: escape state machine, one input word per cycle unless full
  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_end    (in_end_of_string),
    .job       (job),
    .job_valid (job_valid)
  );

  // job queue decouples decoder from output stalls
  jsu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept && job_valid),
    .wr_job (job),
    .full   (full),
    .rd_en  (head_pop),
    .head   (head)
  );

  // serializer: one result word per pop
  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_pop        (head_pop),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_string_done (out_string_done),
    .out_error_code  (out_error_code)
  );

endmodule
`default_nettype wire

>>> sv/jsu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front - escape decoder
// Classifies each accepted byte and forms the job of result bytes it causes.
// ----------------------------------------------------------------------------
module jsu_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_end,
  output jsu_pkg::job_t     job,
  output logic              job_valid
);

  typedef enum logic [2:0] {
    M_PLAIN,
    M_ESC,
    M_HEX1,
    M_AFTERHIGH,
    M_HIGHESC,
    M_HEX2,
    M_SWALLOW
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  dcnt_r, dcnt_nxt;
  logic [15:0] cval_r, cval_nxt;
  logic [9:0]  high_r, high_nxt;
  logic        hfault_r, hfault_nxt;

  jsu_pkg::esc_t esc;
  jsu_pkg::hex_t hx;
  logic [15:0]   cv_new;
  logic          fault_new;
  logic          dig_done;
  logic [15:0]   high_cp;

  assign esc       = jsu_pkg::simple_escape(in_byte);
  assign hx        = jsu_pkg::hex_digit(in_byte);
  assign cv_new    = {cval_r[11:0], hx.val};
  assign fault_new = hfault_r | hx.bad;
  assign dig_done  = (dcnt_r == 2'd3);
  assign high_cp   = {6'b110110, high_r};

  always_comb begin
    mode_nxt   = mode_r;
    dcnt_nxt   = dcnt_r;
    cval_nxt   = cval_r;
    high_nxt   = high_r;
    hfault_nxt = hfault_r;
    job        = '0;
    job_valid  = 1'b0;
    job.err    = jsu_pkg::ERR_NONE;

    unique case (mode_r)
      M_SWALLOW: ;
      M_ESC, M_HIGHESC: begin
        if (esc.kind == jsu_pkg::ESC_BAD) begin
          job.err   = jsu_pkg::ERR_BAD_ESC;
          job_valid = 1'b1;
        end else if (esc.kind == jsu_pkg::ESC_UNI) begin
          if (in_end) begin
            job.err   = jsu_pkg::ERR_TRUNC_U;
            job_valid = 1'b1;
          end else begin
            mode_nxt   = (mode_r == M_ESC) ? M_HEX1 : M_HEX2;
            dcnt_nxt   = 2'd0;
            cval_nxt   = '0;
            hfault_nxt = 1'b0;
          end
        end else if (mode_r == M_ESC) begin
          job.bytes[0] = esc.val;
          job_valid    = 1'b1;
          mode_nxt     = M_PLAIN;
        end else begin
          // lone high surrogate, then the escaped byte
          job          = jsu_pkg::utf8_encode({5'd0, high_cp});
          job.bytes[3] = esc.val;
          job.last_idx = 2'd3;
          job_valid    = 1'b1;
          mode_nxt     = M_PLAIN;
        end
      end
      M_HEX1, M_HEX2: begin
        cval_nxt   = cv_new;
        dcnt_nxt   = dcnt_r + 2'd1;
        hfault_nxt = fault_new;
        if (!dig_done) begin
          if (in_end) begin
            job.err   = jsu_pkg::ERR_TRUNC_U;
            job_valid = 1'b1;
          end
        end else if (fault_new) begin
          job.err   = jsu_pkg::ERR_BAD_HEX;
          job_valid = 1'b1;
        end else if (mode_r == M_HEX1) begin
          if (cv_new >= jsu_pkg::HI_SURR_LO && cv_new <= jsu_pkg::HI_SURR_HI) begin
            high_nxt = cv_new[9:0];
            mode_nxt = M_AFTERHIGH;
            if (in_end) begin
              job       = jsu_pkg::utf8_encode({5'd0, cv_new});
              job_valid = 1'b1;
            end
          end else begin
            job       = jsu_pkg::utf8_encode({5'd0, cv_new});
            job_valid = 1'b1;
            mode_nxt  = M_PLAIN;
          end
        end else if (cv_new < jsu_pkg::LO_SURR_LO || cv_new > jsu_pkg::LO_SURR_HI) begin
          job.err   = jsu_pkg::ERR_BAD_LOW;
          job_valid = 1'b1;
        end else begin
          job       = jsu_pkg::utf8_encode(jsu_pkg::SUPP_BASE + {1'b0, high_r, cv_new[9:0]});
          job_valid = 1'b1;
          mode_nxt  = M_PLAIN;
        end
      end
      M_AFTERHIGH: begin
        if (in_byte == jsu_pkg::CH_BSLASH) begin
          if (in_end) begin
            job.err   = jsu_pkg::ERR_BSL_END;
            job_valid = 1'b1;
          end else begin
            mode_nxt = M_HIGHESC;
          end
        end else begin
          job          = jsu_pkg::utf8_encode({5'd0, high_cp});
          job.bytes[3] = in_byte;
          job.last_idx = 2'd3;
          job_valid    = 1'b1;
          mode_nxt     = M_PLAIN;
        end
      end
      default: begin
        if (in_byte == jsu_pkg::CH_BSLASH) begin
          if (in_end) begin
            job.err   = jsu_pkg::ERR_BSL_END;
            job_valid = 1'b1;
          end else begin
            mode_nxt = M_ESC;
          end
        end else begin
          job.bytes[0] = in_byte;
          job_valid    = 1'b1;
          mode_nxt     = M_PLAIN;
        end
      end
    endcase

    // error: single zero byte that ends the string, rest swallowed
    if (job.err != jsu_pkg::ERR_NONE) begin
      job.bytes    = '0;
      job.last_idx = 2'd0;
      job.done     = 1'b1;
      mode_nxt     = M_SWALLOW;
      dcnt_nxt     = '0;
      cval_nxt     = '0;
      high_nxt     = '0;
      hfault_nxt   = 1'b0;
    end
    if (in_end) begin
      job.done   = 1'b1;
      mode_nxt   = M_PLAIN;
      dcnt_nxt   = '0;
      cval_nxt   = '0;
      high_nxt   = '0;
      hfault_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_PLAIN;
      dcnt_r   <= '0;
      cval_r   <= '0;
      high_r   <= '0;
      hfault_r <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      dcnt_r   <= dcnt_nxt;
      cval_r   <= cval_nxt;
      high_r   <= high_nxt;
      hfault_r <= hfault_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/jsu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_queue - job queue
// Small FIFO of decoded jobs between decoder and serializer.
// ----------------------------------------------------------------------------
module jsu_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire jsu_pkg::job_t wr_job,
  output logic               full,
  input  wire logic          rd_en,
  output jsu_pkg::qhead_t    head
);

  jsu_pkg::job_t                  mem_r [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QPTR_W-1:0]     wptr_r, rptr_r;
  logic [jsu_pkg::QCNT_W-1:0]     cnt_r;
  logic                           do_wr, do_rd;

  assign full       = (cnt_r == jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.job   = mem_r[rptr_r];
  assign do_wr      = wr_en && !full;
  assign do_rd      = rd_en && head.valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) wptr_r <= wptr_r + jsu_pkg::QPTR_W'(1);
      if (do_rd) rptr_r <= rptr_r + jsu_pkg::QPTR_W'(1);
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + jsu_pkg::QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - jsu_pkg::QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/jsu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back - result serializer
// Sends the bytes of the head job one word at a time.
// ----------------------------------------------------------------------------
module jsu_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire jsu_pkg::qhead_t head,
  output logic                 head_pop,
  output logic                 empty,
  input  wire logic            pop,
  output logic [7:0]           out_byte,
  output logic                 out_last_of_run,
  output logic                 out_string_done,
  output logic [2:0]           out_error_code
);

  logic [1:0] idx_r;
  logic       last;
  logic       take;

  assign empty           = !head.valid;
  assign last            = (idx_r == head.job.last_idx);
  assign take            = pop && head.valid;
  assign head_pop        = take && last;
  assign out_byte        = head.job.bytes[idx_r];
  assign out_last_of_run = last;
  assign out_string_done = last && head.job.done;
  assign out_error_code  = head.job.err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (take) begin
      idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule
`default_nettype wire
